### design/kxsc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kxsc_pkg
// Shared types, codes and the reset contents of the keyed cipher table.
// ----------------------------------------------------------------------------
package kxsc_pkg;

    localparam int unsigned TBL_DEPTH  = 256;
    localparam int unsigned TBL_AW     = 8;
    localparam int unsigned BYTE_W     = 8;
    localparam logic [TBL_AW-1:0] TBL_LAST = 8'd255;
    localparam logic [8:0] KEY_MOD = 9'd255;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [TBL_AW-1:0] addr_t;
    typedef byte_t tbl_t [TBL_DEPTH];

    typedef enum logic [1:0] {
        FUNC_RESTART = 2'd0,
        FUNC_KEY     = 2'd1,
        FUNC_DATA    = 2'd2,
        FUNC_NONE    = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_J,
        ST_MUL,
        ST_RD_S,
        ST_WR_J,
        ST_WR_S
    } state_t;

    typedef struct packed {
        logic  en;
        addr_t addr;
    } tbl_rd_t;

    typedef struct packed {
        logic  en;
        addr_t addr;
        byte_t data;
    } tbl_wr_t;

    // Multiplication by 3 in GF(2^8) with the polynomial 0x11B.
    function automatic byte_t gf_times3(input byte_t v);
        byte_t dbl;
        dbl = {v[6:0], 1'b0};
        if (v[7]) begin
            dbl = dbl ^ 8'h1B;
        end
        return dbl ^ v;
    endfunction

    // Entry i holds 3^i; the last entry holds 1 since 3 has order 255.
    function automatic tbl_t pow3_table();
        tbl_t  t;
        byte_t p;
        p = 8'h01;
        for (int i = 0; i < TBL_DEPTH; i++) begin
            t[i] = p;
            p = gf_times3(p);
        end
        t[TBL_DEPTH-1] = 8'h01;
        return t;
    endfunction

    localparam tbl_t POW3 = pow3_table();

endpackage
`default_nettype wire

### design/keyed_table_xor_stream_cipher_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// keyed_table_xor_stream_cipher_top
// Keyed-table XOR stream cipher: a 256-byte table keyed by swap passes, with
// each data word XORed against the table entry at a running byte position.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake           Payload
//  s_        in         s_valid / s_ready   s_func, s_key_byte, s_data_byte
//  m_        out        m_valid / m_ready   m_byte_out
//
// A data word is taken every cycle while the output keeps draining; the table
// read at its byte position is registered together with the word in the read
// stage, and the output register loads their XOR once the output is free.
// A key word runs a swap pass over all 256 entries through the single table
// memory, stepping through RD_J, MUL, RD_S and WR_J for each entry and adding
// WR_S when a swap is needed; no word is taken during the pass.
// A restart word clears the table's valid bits at once, and invalid entries
// read as their reset contents, so no clearing pass exists.
// Reset (aresetn low, synchronous) empties the pipeline, zeroes the position
// and marks every table entry as holding its reset value.
// A stalled output holds its word; input is refused while the read stage is
// full and the output stage holds a stalled word.
// ----------------------------------------------------------------------------
module keyed_table_xor_stream_cipher_top (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  wire  [1:0]          s_func,
    input  wire  [7:0]          s_key_byte,
    input  wire  [7:0]          s_data_byte,
    output logic                m_valid,
    input  wire                 m_ready,
    output logic [7:0]          m_byte_out
);

    kxsc_pkg::state_t state_reg, state_next;

    kxsc_pkg::addr_t j_reg, j_next;
    kxsc_pkg::addr_t s_reg, s_next;
    kxsc_pkg::byte_t key_reg, key_next;
    kxsc_pkg::byte_t tj_reg, tj_next;
    logic [15:0]     prod_reg, prod_next;
    kxsc_pkg::addr_t pos_reg, pos_next;

    logic            d1_valid_reg, d1_valid_next;
    kxsc_pkg::byte_t d1_data_reg, d1_data_next;
    logic            m_valid_reg, m_valid_next;
    kxsc_pkg::byte_t m_byte_out_reg, m_byte_out_next;

    kxsc_pkg::tbl_rd_t tbl_rd;
    kxsc_pkg::tbl_wr_t tbl_wr;
    kxsc_pkg::byte_t   tbl_rd_data;
    logic              tbl_clr;

    logic              in_fire;
    logic              out_free;
    logic [8:0]        mod_sum;
    kxsc_pkg::addr_t   mod_s;

    kxsc_pkg::func_t   func;

    assign func     = kxsc_pkg::func_t'(s_func);
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == kxsc_pkg::ST_IDLE) && (!d1_valid_reg || out_free);
    assign in_fire  = s_valid && s_ready;

    // (x mod 255): 256 is 1 modulo 255, so fold the high byte onto the low
    // byte; the folded sum stays below 510, so one subtract finishes it.
    assign mod_sum = {1'b0, prod_reg[15:8]} + {1'b0, prod_reg[7:0]};
    assign mod_s   = (mod_sum >= kxsc_pkg::KEY_MOD) ? 8'(mod_sum - kxsc_pkg::KEY_MOD)
                                                    : mod_sum[7:0];

    kxsc_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clr     (tbl_clr),
        .rd      (tbl_rd),
        .wr      (tbl_wr),
        .rd_data (tbl_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= kxsc_pkg::ST_IDLE;
            pos_reg      <= '0;
            d1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pos_reg      <= pos_next;
            d1_valid_reg <= d1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        j_reg          <= j_next;
        s_reg          <= s_next;
        key_reg        <= key_next;
        tj_reg         <= tj_next;
        prod_reg       <= prod_next;
        d1_data_reg    <= d1_data_next;
        m_byte_out_reg <= m_byte_out_next;
    end

    // Sequencer for the key pass and the data path.
    always_comb begin
        state_next      = state_reg;
        j_next          = j_reg;
        s_next          = s_reg;
        key_next        = key_reg;
        tj_next         = tj_reg;
        prod_next       = prod_reg;
        pos_next        = pos_reg;
        d1_valid_next   = d1_valid_reg;
        d1_data_next    = d1_data_reg;
        m_valid_next    = m_valid_reg;
        m_byte_out_next = m_byte_out_reg;
        tbl_rd          = '0;
        tbl_wr          = '0;
        tbl_clr         = 1'b0;

        // Output stage: the read stage moves on whenever the output is free.
        if (d1_valid_reg && out_free) begin
            m_valid_next    = 1'b1;
            m_byte_out_next = d1_data_reg ^ tbl_rd_data;
            d1_valid_next   = 1'b0;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            kxsc_pkg::ST_IDLE: begin
                if (in_fire) begin
                    unique case (func)
                        kxsc_pkg::FUNC_RESTART: begin
                            tbl_clr  = 1'b1;
                            pos_next = '0;
                        end
                        kxsc_pkg::FUNC_KEY: begin
                            key_next   = s_key_byte;
                            j_next     = '0;
                            state_next = kxsc_pkg::ST_RD_J;
                        end
                        kxsc_pkg::FUNC_DATA: begin
                            tbl_rd.en     = 1'b1;
                            tbl_rd.addr   = pos_reg;
                            d1_valid_next = 1'b1;
                            d1_data_next  = s_data_byte;
                            pos_next      = pos_reg + 8'd1;
                        end
                        kxsc_pkg::FUNC_NONE: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end
            kxsc_pkg::ST_RD_J: begin
                tbl_rd.en   = 1'b1;
                tbl_rd.addr = j_reg;
                state_next  = kxsc_pkg::ST_MUL;
            end
            kxsc_pkg::ST_MUL: begin
                tj_next    = tbl_rd_data;
                prod_next  = tbl_rd_data * key_reg;
                state_next = kxsc_pkg::ST_RD_S;
            end
            kxsc_pkg::ST_RD_S: begin
                s_next      = mod_s;
                tbl_rd.en   = 1'b1;
                tbl_rd.addr = mod_s;
                state_next  = kxsc_pkg::ST_WR_J;
            end
            kxsc_pkg::ST_WR_J: begin
                if (s_reg != j_reg) begin
                    tbl_wr.en   = 1'b1;
                    tbl_wr.addr = j_reg;
                    tbl_wr.data = tbl_rd_data;
                    state_next  = kxsc_pkg::ST_WR_S;
                end else if (j_reg == kxsc_pkg::TBL_LAST) begin
                    state_next = kxsc_pkg::ST_IDLE;
                end else begin
                    j_next     = j_reg + 8'd1;
                    state_next = kxsc_pkg::ST_RD_J;
                end
            end
            kxsc_pkg::ST_WR_S: begin
                tbl_wr.en   = 1'b1;
                tbl_wr.addr = s_reg;
                tbl_wr.data = tj_reg;
                if (j_reg == kxsc_pkg::TBL_LAST) begin
                    state_next = kxsc_pkg::ST_IDLE;
                end else begin
                    j_next     = j_reg + 8'd1;
                    state_next = kxsc_pkg::ST_RD_J;
                end
            end
            default: begin
                state_next = kxsc_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid    = m_valid_reg;
    assign m_byte_out = m_byte_out_reg;

`ifndef SYNTHESIS
    // A key word must start a swap pass on the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && (s_func == kxsc_pkg::FUNC_KEY) |=> state_reg == kxsc_pkg::ST_RD_J)
        else $error("key word did not start a swap pass");

    // No data read may be pending while the swap pass owns the table port.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != kxsc_pkg::ST_IDLE |-> !d1_valid_reg)
        else $error("data read pending during swap pass");

    // The byte position moves only when a word is accepted.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !in_fire |=> $stable(pos_reg))
        else $error("byte position changed without an accepted word");

    // Table writes happen only in the two write steps of the pass.
    assert property (@(posedge aclk) disable iff (!aresetn)
        tbl_wr.en |-> (state_reg == kxsc_pkg::ST_WR_J) || (state_reg == kxsc_pkg::ST_WR_S))
        else $error("table write outside the swap steps");
`endif

endmodule
`default_nettype wire

### design/kxsc_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kxsc_table
// 256 x 8 table memory with one read and one write port, registered read
// data, and per-entry valid bits so that a restart reloads it at once.
// ----------------------------------------------------------------------------
module kxsc_table (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  clr,
    input  kxsc_pkg::tbl_rd_t    rd,
    input  kxsc_pkg::tbl_wr_t    wr,
    output kxsc_pkg::byte_t      rd_data
);

    kxsc_pkg::byte_t mem [kxsc_pkg::TBL_DEPTH];
    logic [kxsc_pkg::TBL_DEPTH-1:0] valid_reg;
    kxsc_pkg::byte_t rdata_reg;
    kxsc_pkg::addr_t raddr_reg;
    logic            rvalid_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en) begin
            rdata_reg <= mem[rd.addr];
            raddr_reg <= rd.addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end else begin
            if (clr) begin
                valid_reg <= '0;
            end else if (wr.en) begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (rd.en) begin
                rvalid_reg <= valid_reg[rd.addr];
            end
        end
    end

    // An entry never written since the last restart reads as its power of three.
    assign rd_data = rvalid_reg ? rdata_reg : kxsc_pkg::POW3[raddr_reg];

endmodule
`default_nettype wire
